@@ hw/rtl/sat_pkg.sv @@
// Shared types and codes for the section address translator.
`timescale 1ns / 1ps

package sat_pkg;

  localparam logic [1:0] KIND_LOAD = 2'd0;
  localparam logic [1:0] KIND_V2F  = 2'd1;
  localparam logic [1:0] KIND_F2V  = 2'd2;

  localparam logic [1:0] STATUS_HIT      = 2'd0;
  localparam logic [1:0] STATUS_MISS     = 2'd1;
  localparam logic [1:0] STATUS_OVERFLOW = 2'd2;

  localparam logic [31:0] ALL_ONES = 32'hFFFF_FFFF;

  typedef struct packed {
    logic [1:0]  kind;
    logic [3:0]  entry_index;
    logic [31:0] virt_start;
    logic [31:0] virt_size;
    logic [31:0] raw_start;
    logic [31:0] raw_size;
    logic [31:0] query_addr;
  } in_req_t;

  typedef struct packed {
    logic [31:0] result_addr;
    logic [1:0]  status;
    logic [3:0]  hit_slot;
  } out_rsp_t;

  typedef struct packed {
    logic accept;
    logic start_scan;
    logic rd_en;
    logic cmp_en;
    logic next_entry;
    logic sum_en;
    logic set_miss;
    logic out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic in_query;
    logic limit_zero;
    logic last_entry;
    logic hit;
  } dp_status_t;

endpackage

@@ hw/rtl/sat_datapath.sv @@
// Datapath: section table, entry compare, address sum and result registers.
`timescale 1ns / 1ps

module sat_datapath #(
  parameter int MAX_SECTIONS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  sat_pkg::in_req_t   in_req_i,
  input  logic               cfg_valid_i,
  input  logic [4:0]         cfg_data_i,
  input  sat_pkg::ctrl_cmd_t cmd_i,
  output sat_pkg::dp_status_t status_o,
  output sat_pkg::out_rsp_t  out_rsp_o
);

  localparam int IDX_W = (MAX_SECTIONS > 1) ? $clog2(MAX_SECTIONS) : 1;
  localparam int LIM_C = $clog2(MAX_SECTIONS + 1);
  localparam int LIM_W = (LIM_C > 5) ? LIM_C : 5;

  logic [31:0] mem_vs [MAX_SECTIONS];
  logic [31:0] mem_vz [MAX_SECTIONS];
  logic [31:0] mem_rs [MAX_SECTIONS];
  logic [31:0] mem_rz [MAX_SECTIONS];

  logic [4:0]       count_q;
  logic [IDX_W-1:0] idx_q;
  logic [1:0]       kind_q;
  logic [31:0]      addr_q;
  logic [31:0]      base_q, len_q, other_q;
  logic             hit_q;
  logic [31:0]      delta_q;
  sat_pkg::out_rsp_t res_q, out_q;

  logic [LIM_W-1:0] count_ext, limit;
  logic [IDX_W-1:0] wr_addr;
  logic             wr_en;
  logic [32:0]      hi_full, sum_full;
  logic [31:0]      hi_clamped;

  assign count_ext = LIM_W'(count_q);
  assign limit     = (count_ext > LIM_W'(MAX_SECTIONS)) ? LIM_W'(MAX_SECTIONS) : count_ext;
  assign wr_addr   = IDX_W'(in_req_i.entry_index);
  assign wr_en     = cmd_i.accept && (in_req_i.kind == sat_pkg::KIND_LOAD) &&
                     (int'(in_req_i.entry_index) < MAX_SECTIONS);

  assign hi_full    = {1'b0, base_q} + {1'b0, len_q};
  assign hi_clamped = hi_full[32] ? sat_pkg::ALL_ONES : hi_full[31:0];
  assign sum_full   = {1'b0, other_q} + {1'b0, delta_q};

  assign status_o.in_query   = (in_req_i.kind == sat_pkg::KIND_V2F) ||
                               (in_req_i.kind == sat_pkg::KIND_F2V);
  assign status_o.limit_zero = (limit == '0);
  assign status_o.last_entry = ((LIM_W'(idx_q) + LIM_W'(1)) == limit);
  assign status_o.hit        = hit_q;
  assign out_rsp_o           = out_q;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_vs[wr_addr] <= in_req_i.virt_start;
      mem_vz[wr_addr] <= in_req_i.virt_size;
      mem_rs[wr_addr] <= in_req_i.raw_start;
      mem_rz[wr_addr] <= in_req_i.raw_size;
    end
    if (cmd_i.rd_en) begin
      if (kind_q == sat_pkg::KIND_V2F) begin
        base_q  <= mem_vs[idx_q];
        len_q   <= mem_vz[idx_q];
        other_q <= mem_rs[idx_q];
      end else begin
        base_q  <= mem_rs[idx_q];
        len_q   <= mem_rz[idx_q];
        other_q <= mem_vs[idx_q];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      idx_q   <= '0;
    end else begin
      if (cfg_valid_i) begin
        count_q <= cfg_data_i;
      end
      if (cmd_i.start_scan) begin
        idx_q <= '0;
      end else if (cmd_i.next_entry) begin
        idx_q <= idx_q + IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      kind_q <= in_req_i.kind;
      addr_q <= in_req_i.query_addr;
    end
    if (cmd_i.cmp_en) begin
      hit_q   <= (addr_q >= base_q) && (addr_q < hi_clamped);
      delta_q <= addr_q - base_q;
    end
    if (cmd_i.sum_en) begin
      if (sum_full[32]) begin
        res_q.result_addr <= '0;
        res_q.status      <= sat_pkg::STATUS_OVERFLOW;
        res_q.hit_slot    <= '0;
      end else begin
        res_q.result_addr <= sum_full[31:0];
        res_q.status      <= sat_pkg::STATUS_HIT;
        res_q.hit_slot    <= 4'(idx_q);
      end
    end else if (cmd_i.set_miss) begin
      res_q.result_addr <= '0;
      res_q.status      <= sat_pkg::STATUS_MISS;
      res_q.hit_slot    <= '0;
    end
    if (cmd_i.out_load) begin
      out_q <= res_q;
    end
  end

endmodule

@@ hw/rtl/sat_controller.sv @@
// Controller: sequences the table scan and owns the request handshakes.
`timescale 1ns / 1ps

module sat_controller (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  input  sat_pkg::dp_status_t status_i,
  output sat_pkg::ctrl_cmd_t  cmd_o
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_READ = 3'd1;
  localparam logic [2:0] S_CMP  = 3'd2;
  localparam logic [2:0] S_EVAL = 3'd3;
  localparam logic [2:0] S_SUM  = 3'd4;
  localparam logic [2:0] S_DONE = 3'd5;

  logic [2:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       out_free;

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_free    = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q && out_stall_i;
    cmd_o       = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          if (status_i.in_query) begin
            if (status_i.limit_zero) begin
              cmd_o.set_miss = 1'b1;
              state_d        = S_DONE;
            end else begin
              cmd_o.start_scan = 1'b1;
              state_d          = S_READ;
            end
          end
        end
      end
      S_READ: begin
        cmd_o.rd_en = 1'b1;
        state_d     = S_CMP;
      end
      S_CMP: begin
        cmd_o.cmp_en = 1'b1;
        state_d      = S_EVAL;
      end
      S_EVAL: begin
        priority if (status_i.hit) begin
          state_d = S_SUM;
        end else if (status_i.last_entry) begin
          cmd_o.set_miss = 1'b1;
          state_d        = S_DONE;
        end else begin
          cmd_o.next_entry = 1'b1;
          state_d          = S_READ;
        end
      end
      S_SUM: begin
        cmd_o.sum_en = 1'b1;
        state_d      = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          cmd_o.out_load = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

@@ hw/rtl/section_address_translator_unit.sv @@
// Top level of the section address translator.
// A load request writes its table entry when accepted and gives no result; a translate
// request checks one table entry at a time (registered table read, range compare, decision)
// over min(section_count, MAX_SECTIONS) entries from slot 0 and stops at the first hit. The next
// request is taken once a result is registered, and a stalled result holds it at the end.
// Reset clears the controller and section_count; the table is undefined until loaded.
`timescale 1ns / 1ps

module section_address_translator_unit #(
  parameter int MAX_SECTIONS = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  sat_pkg::in_req_t  in_req_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output sat_pkg::out_rsp_t out_rsp_o,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [4:0]        cfg_data_i
);

  sat_pkg::ctrl_cmd_t  cmd;
  sat_pkg::dp_status_t status;

  assign cfg_ready_o = 1'b1;

  sat_controller u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  sat_datapath #(
    .MAX_SECTIONS (MAX_SECTIONS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_req_i    (in_req_i),
    .cfg_valid_i (cfg_valid_i && cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_rsp_o   (out_rsp_o)
  );

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_rsp_o.status != sat_pkg::STATUS_HIT) |->
      (out_rsp_o.result_addr == '0) && (out_rsp_o.hit_slot == '0))
    else $error("Non-hit result carries an address or slot.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_rsp_o.status == sat_pkg::STATUS_HIT) ||
      (out_rsp_o.status == sat_pkg::STATUS_MISS) ||
      (out_rsp_o.status == sat_pkg::STATUS_OVERFLOW))
    else $error("Result status code is not defined.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_rsp_o.status == sat_pkg::STATUS_HIT) |->
      (int'(out_rsp_o.hit_slot) < MAX_SECTIONS))
    else $error("Hit slot lies outside the section table.");

endmodule
